// File: rtl/kmp_stream_matcher_assert.svh
// Assertion macros for the matcher's RTL, used by kmp_datapath.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KMP_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kmp_pkg.sv
// Types and constants shared by the KMP stream matcher modules.
package kmp_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int PREFIX_BITS = 6;
  localparam int START_BITS  = 32;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   start_req;
  } in_beat_t;

  typedef struct packed {
    logic [PREFIX_BITS-1:0] prefix_value;
    logic                   match;
    logic [START_BITS-1:0]  match_start;
    logic                   error;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } dp_status_t;

endpackage

// File: rtl/kmp_datapath.sv
// KMP datapath: pattern and prefix memories, scan state, table walk and result register.
`include "kmp_stream_matcher_assert.svh"

module kmp_datapath #(
  parameter int PATTERN_MAX    = 64,
  parameter int SYMBOL_WIDTH   = 8,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kmp_pkg::ctrl_cmd_t  cmd,
  input  kmp_pkg::in_beat_t   item,
  output kmp_pkg::dp_status_t status,
  output logic                done,
  output kmp_pkg::out_beat_t  result
);

  localparam int AW = $clog2(PATTERN_MAX);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int SW = SYMBOL_WIDTH;
  localparam int PW = POSITION_WIDTH;

  logic [SW-1:0] store_mem [PATTERN_MAX];
  logic [AW-1:0] prefix_mem [PATTERN_MAX];
  logic [SW-1:0] store_q;
  logic [AW-1:0] prefix_q;

  logic [LW-1:0] len;
  logic [AW-1:0] progress;
  logic [AW-1:0] matched;
  logic [PW-1:0] pos;

  logic          is_text;
  logic [SW-1:0] sym;
  logic [LW-1:0] k;

  logic [SW+7:0] sym_ext;
  logic [SW-1:0] sym_in;
  logic          clear_pat;
  logic [LW-1:0] len_load;
  logic [AW-1:0] progress_load;
  logic [AW-1:0] matched_load;
  logic [PW-1:0] pos_load;

  logic          full;
  logic          empty;
  logic          hit;
  logic          walk_done;
  logic          is_match;
  logic [LW-1:0] rd_addr;
  logic [LW-1:0] prefix_addr;

  logic [LW+5:0]    pv_ext;
  logic [LW+PW-1:0] len_ext;
  logic [PW-1:0]    ms_full;
  logic [PW+31:0]   ms_ext;

  assign sym_ext = {{SW{1'b0}}, item.symbol};
  assign sym_in  = sym_ext[SW-1:0];

  assign clear_pat     = (item.func == kmp_pkg::FUNC_PATTERN) && item.start_req;
  assign len_load      = clear_pat ? '0 : len;
  assign progress_load = clear_pat ? '0 : progress;
  assign matched_load  = item.start_req ? '0 : matched;
  assign pos_load      = item.start_req ? '0 : pos;

  assign full      = len >= LW'(PATTERN_MAX);
  assign empty     = len == '0;
  assign hit       = store_q == sym;
  assign walk_done = hit || (k == '0);
  assign is_match  = is_text && !empty && (k == len);

  assign status.need_walk = !empty && (is_text || !full);
  assign status.walk_done = walk_done;

  // failing step re-reads at the fallback length; a hit reads prefix[k] for the match tail
  always_comb begin
    rd_addr = k;
    if (cmd.walk) begin
      if (!walk_done) begin
        rd_addr = LW'(prefix_q);
      end else if (hit) begin
        rd_addr = LW'(k + 1'b1);
      end
    end
  end

  assign prefix_addr = rd_addr - LW'(1);

  assign pv_ext  = {6'b0, k};
  assign len_ext = {{PW{1'b0}}, len};
  assign ms_full = pos - len_ext[PW-1:0] + PW'(1);
  assign ms_ext  = {32'b0, ms_full};

  always_ff @(posedge clk) begin
    store_q  <= store_mem[rd_addr[AW-1:0]];
    prefix_q <= prefix_mem[prefix_addr[AW-1:0]];
    if (cmd.commit && !is_text && !full) begin
      store_mem[len[AW-1:0]]  <= sym;
      prefix_mem[len[AW-1:0]] <= k[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_text <= item.func == kmp_pkg::FUNC_TEXT;
      sym     <= sym_in;
      k       <= (item.func == kmp_pkg::FUNC_TEXT) ? LW'(matched_load) : LW'(progress_load);
    end else if (cmd.walk) begin
      if (walk_done) begin
        k <= hit ? LW'(k + 1'b1) : '0;
      end else begin
        k <= LW'(prefix_q);
      end
    end
    if (cmd.commit) begin
      result.prefix_value <= (!is_text && !full) ? pv_ext[5:0] : '0;
      result.match        <= is_match;
      result.match_start  <= is_match ? ms_ext[31:0] : '0;
      result.error        <= is_text ? empty : full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      progress <= '0;
      matched  <= '0;
      pos      <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.load) begin
        len      <= len_load;
        progress <= progress_load;
        matched  <= matched_load;
        pos      <= pos_load;
      end else if (cmd.commit) begin
        if (!is_text) begin
          if (!full) begin
            len      <= LW'(len + 1'b1);
            progress <= k[AW-1:0];
          end
        end else begin
          if (!empty) begin
            matched <= is_match ? prefix_q : k[AW-1:0];
          end
          pos <= pos + PW'(1);
        end
      end
    end
  end

  `KMP_ASSERT_HOLD(a_matched_below_len, len != '0, LW'(matched) < len, "matched past length")
  `KMP_ASSERT_HOLD(a_empty_scan_clear, len == '0, matched == '0 && progress == '0, "stale scan")
  `KMP_ASSERT_HOLD(a_walk_in_range, cmd.walk, k < len, "table walk beyond stored pattern")
  `KMP_ASSERT_NEXT(a_walk_shrinks, cmd.walk && !walk_done, k < $past(k), "walk stalled")
  `KMP_ASSERT_NEXT(a_commit_strobes, cmd.commit, done, "commit without result strobe")

endmodule

// File: rtl/kmp_ctrl.sv
// KMP controller: sequences load, table walk and commit for one beat.
module kmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  kmp_pkg::dp_status_t status,
  output kmp_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  kmp_pkg::ctrl_state_t state;
  kmp_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kmp_pkg::ST_IDLE: begin
        if (start) state_next = kmp_pkg::ST_CHECK;
      end
      kmp_pkg::ST_CHECK: begin
        state_next = status.need_walk ? kmp_pkg::ST_WALK : kmp_pkg::ST_COMMIT;
      end
      kmp_pkg::ST_WALK: begin
        if (status.walk_done) state_next = kmp_pkg::ST_COMMIT;
      end
      kmp_pkg::ST_COMMIT: begin
        state_next = kmp_pkg::ST_IDLE;
      end
      default: begin
        state_next = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      kmp_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      kmp_pkg::ST_CHECK: begin
        cmd = '0;
      end
      kmp_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
      end
      kmp_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/kmp_stream_matcher.sv
// Top level of the KMP stream matcher: controller plus datapath.
// A beat is taken when start is high and busy is low; its result is on done for one cycle.
// Busy is high in check, walk and commit, so one beat is in flight; the next can be taken while done is high.
// The walk compares the symbol and, on each failure, takes one failure-table step; it is skipped for a
// first pattern symbol, an overflow or an empty-pattern text symbol, and ends on a hit or at length zero.
// No result stall. Synchronous rst empties the pattern and clears the scan; memories are kept.
module kmp_stream_matcher #(
  parameter int PATTERN_MAX    = 64,
  parameter int SYMBOL_WIDTH   = 8,
  parameter int POSITION_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  kmp_pkg::in_beat_t  item,
  output logic               done,
  output kmp_pkg::out_beat_t result
);

  kmp_pkg::ctrl_cmd_t  cmd;
  kmp_pkg::dp_status_t status;

  kmp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  kmp_datapath #(
    .PATTERN_MAX    (PATTERN_MAX),
    .SYMBOL_WIDTH   (SYMBOL_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
